FILE: src/fdre_pkg.sv
package fdre_pkg;

    localparam int COORD_BITS   = 12;
    localparam int CFG_BITS     = COORD_BITS + 1;
    localparam int CFG_IDX_BITS = 3;
    localparam int PIX_W        = 32;
    localparam int VALUE_W      = 32;
    localparam int MAX_RES      = 4;
    localparam int RES_CNT_BITS = $clog2(MAX_RES + 1);

    localparam logic [COORD_BITS:0] SIZE_LIMIT = (CFG_BITS)'(1 << COORD_BITS);

    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN = 3'd4;

    typedef enum logic [2:0] {
        K_RESET_POS = 3'd0,
        K_SKIP      = 3'd1,
        K_PUT       = 3'd2,
        K_REPEAT    = 3'd3,
        K_UPDATE    = 3'd4
    } t_kind;

    typedef struct packed {
        logic [PIX_W-1:0] old_pixel;
        logic [PIX_W-1:0] new_pixel;
    } t_in;

    typedef struct packed {
        t_kind                 kind;
        logic [VALUE_W-1:0]    value;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [CFG_BITS-1:0]   box_w;
        logic [CFG_BITS-1:0]   box_h;
        logic                  last;
    } t_out;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [CFG_BITS-1:0]   width;
        logic [CFG_BITS-1:0]   height;
        logic [CFG_BITS-1:0]   screen;
    } t_cfg;

    typedef struct packed {
        logic [RES_CNT_BITS-1:0] count;
        t_out [MAX_RES-1:0]      entry;
    } t_bundle;

    // zero acts as one, anything past the coordinate range is clamped
    function automatic logic [COORD_BITS:0] eff_size(input logic [COORD_BITS:0] s);
        logic [COORD_BITS:0] r;
        if (s == '0) begin
            r = (CFG_BITS)'(1);
        end else if (s > SIZE_LIMIT) begin
            r = SIZE_LIMIT;
        end else begin
            r = s;
        end
        return r;
    endfunction

    function automatic t_out mk_res(input t_kind k, input logic [VALUE_W-1:0] v,
                                    input logic [COORD_BITS-1:0] px,
                                    input logic [COORD_BITS-1:0] py,
                                    input logic [CFG_BITS-1:0] bw,
                                    input logic [CFG_BITS-1:0] bh);
        t_out r;
        r.kind  = k;
        r.value = v;
        r.pos_x = px;
        r.pos_y = py;
        r.box_w = bw;
        r.box_h = bh;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

FILE: src/fdre_core.sv
module fdre_core #(
    parameter int COUNT_BITS = 24,
    parameter int PIXEL_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_step,
    input  fdre_pkg::t_in    i_pix,
    input  fdre_pkg::t_cfg   i_cfg,
    output fdre_pkg::t_bundle o_bundle
);
    import fdre_pkg::*;

    localparam logic [COUNT_BITS-1:0] CountMax = '1;
    localparam int SumW = ((COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS) + 1;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [CFG_BITS-1:0] b);
        logic [SumW-1:0] s;
        s = SumW'(a) + SumW'(b);
        return (s > SumW'(CountMax)) ? CountMax : s[COUNT_BITS-1:0];
    endfunction

    // position is held as an offset so a register write can restart it at once
    logic [COORD_BITS-1:0] r_col_off, n_col_off, r_row_off, n_row_off;
    logic [PIXEL_BITS-1:0] r_color, n_color;
    logic [COUNT_BITS-1:0] r_skip, n_skip, r_rep_cnt, n_rep_cnt;
    logic                  r_rep_open, n_rep_open, r_any, n_any;
    logic [COORD_BITS-1:0] r_min_x, n_min_x, r_max_x, n_max_x;
    logic [COORD_BITS-1:0] r_min_y, n_min_y, r_max_y, n_max_y;

    logic [COORD_BITS:0]     w_eff, h_eff;
    logic [CFG_BITS-1:0]     gap;
    logic [COORD_BITS-1:0]   col, row;
    logic [PIXEL_BITS-1:0]   pix_old, pix_new;
    logic                    changed, col_last, row_last;
    logic [RES_CNT_BITS-1:0] k, km1;
    t_out [MAX_RES-1:0]      res;

    assign w_eff    = eff_size(i_cfg.width);
    assign h_eff    = eff_size(i_cfg.height);
    assign gap      = i_cfg.screen - w_eff;
    assign col      = i_cfg.left + r_col_off;
    assign row      = i_cfg.top + r_row_off;
    assign pix_old  = i_pix.old_pixel[PIXEL_BITS-1:0];
    assign pix_new  = i_pix.new_pixel[PIXEL_BITS-1:0];
    assign changed  = pix_old != pix_new;
    assign col_last = {1'b0, r_col_off} >= (w_eff - (COORD_BITS+1)'(1));
    assign row_last = {1'b0, r_row_off} >= (h_eff - (COORD_BITS+1)'(1));

    always_comb begin
        n_col_off  = r_col_off;
        n_row_off  = r_row_off;
        n_color    = r_color;
        n_skip     = r_skip;
        n_rep_cnt  = r_rep_cnt;
        n_rep_open = r_rep_open;
        n_any      = r_any;
        n_min_x    = r_min_x;
        n_max_x    = r_max_x;
        n_min_y    = r_min_y;
        n_max_y    = r_max_y;
        k          = '0;
        res        = '0;

        if (changed) begin
            if (!r_any) begin
                res[k[1:0]] = mk_res(K_RESET_POS, '0, i_cfg.left, i_cfg.top, '0, '0);
                k       = k + 1'b1;
                n_any   = 1'b1;
                n_min_x = col;
                n_max_x = col;
                n_min_y = row;
                n_max_y = row;
            end else begin
                if (col < r_min_x) n_min_x = col;
                if (col > r_max_x) n_max_x = col;
                if (row < r_min_y) n_min_y = row;
                if (row > r_max_y) n_max_y = row;
            end
            if (r_skip != '0) begin
                res[k[1:0]] = mk_res(K_SKIP, VALUE_W'(r_skip), '0, '0, '0, '0);
                k      = k + 1'b1;
                n_skip = '0;
            end
            if (pix_new != r_color) begin
                if (r_rep_open) begin
                    res[k[1:0]] = mk_res(K_REPEAT, VALUE_W'(r_rep_cnt), '0, '0, '0, '0);
                    k = k + 1'b1;
                end
                n_rep_open  = 1'b0;
                n_rep_cnt   = '0;
                res[k[1:0]] = mk_res(K_PUT, VALUE_W'(pix_new), '0, '0, '0, '0);
                k       = k + 1'b1;
                n_color = pix_new;
            end else if (r_rep_open) begin
                n_rep_cnt = sat_add(r_rep_cnt, (CFG_BITS)'(1));
            end else begin
                n_rep_open = 1'b1;
                n_rep_cnt  = (COUNT_BITS)'(1);
            end
        end else begin
            if (r_rep_open) begin
                res[k[1:0]] = mk_res(K_REPEAT, VALUE_W'(r_rep_cnt), '0, '0, '0, '0);
                k = k + 1'b1;
            end
            n_rep_open = 1'b0;
            n_rep_cnt  = '0;
            n_skip     = sat_add(r_skip, (CFG_BITS)'(1));
        end

        if (col_last) begin
            if (row_last) begin
                if (n_rep_open) begin
                    res[k[1:0]] = mk_res(K_REPEAT, VALUE_W'(n_rep_cnt), '0, '0, '0, '0);
                    k = k + 1'b1;
                end
                // trailing skip is dropped; box closes the region
                if (n_any) begin
                    res[k[1:0]] = mk_res(K_UPDATE, '0, n_min_x, n_min_y,
                                         {1'b0, n_max_x} - {1'b0, n_min_x} + (CFG_BITS)'(1),
                                         {1'b0, n_max_y} - {1'b0, n_min_y} + (CFG_BITS)'(1));
                    k = k + 1'b1;
                end
                n_col_off  = '0;
                n_row_off  = '0;
                n_skip     = '0;
                n_rep_open = 1'b0;
                n_rep_cnt  = '0;
                n_any      = 1'b0;
                n_min_x    = '0;
                n_max_x    = '0;
                n_min_y    = '0;
                n_max_y    = '0;
            end else begin
                if ({1'b0, i_cfg.screen} > {1'b0, w_eff}) begin
                    n_skip = sat_add(n_skip, gap);
                    if (n_rep_open) begin
                        res[k[1:0]] = mk_res(K_REPEAT, VALUE_W'(n_rep_cnt), '0, '0, '0, '0);
                        k = k + 1'b1;
                    end
                    n_rep_open = 1'b0;
                    n_rep_cnt  = '0;
                end
                n_col_off = '0;
                n_row_off = r_row_off + 1'b1;
            end
        end else begin
            n_col_off = r_col_off + 1'b1;
        end

        km1 = k - 1'b1;
        if (k != '0) begin
            res[km1[1:0]].last = 1'b1;
        end
    end

    assign o_bundle.count = k;
    assign o_bundle.entry = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col_off  <= '0;
            r_row_off  <= '0;
            r_skip     <= '0;
            r_rep_cnt  <= '0;
            r_rep_open <= 1'b0;
            r_any      <= 1'b0;
            r_min_x    <= '0;
            r_max_x    <= '0;
            r_min_y    <= '0;
            r_max_y    <= '0;
        end else if (i_step) begin
            r_col_off  <= n_col_off;
            r_row_off  <= n_row_off;
            r_skip     <= n_skip;
            r_rep_cnt  <= n_rep_cnt;
            r_rep_open <= n_rep_open;
            r_any      <= n_any;
            r_min_x    <= n_min_x;
            r_max_x    <= n_max_x;
            r_min_y    <= n_min_y;
            r_max_y    <= n_max_y;
        end
    end

    // colour survives register writes, only reset clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= '0;
        end else if (i_step && !i_clear) begin
            r_color <= n_color;
        end
    end

endmodule

FILE: src/frame_diff_run_encoder_unit.sv
// Frame delta run-length encoder.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one old/new pixel
// pair per transaction, in raster order over the configured region. Output
// channel (o_out_valid / i_out_ready / o_out_data) gives drawing commands:
// reset position, skip, put colour, repeat and the closing partial update,
// with last set on the final command a pixel causes.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx in the same
// cycle (left, top, width, height, screen width); a write to any of these restarts the
// region. Write only while the block is idle.
// A pixel's commands pass the input register, then the command bundle register.
// Throughput: one pixel per cycle while each pixel gives at most one command
// and the receiver is ready. A pixel giving k commands (k is at most 4) holds
// the next one until all are taken: the bundle register refills once drained.
// Reset (synchronous, active low) clears the registers to a 1x1 region at the
// origin and the current colour to zero. A stalled receiver holds the output
// command; one more pixel waits in the input register, then o_in_ready drops.
module frame_diff_run_encoder_unit #(
    parameter int COUNT_BITS = 24,
    parameter int PIXEL_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  fdre_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output fdre_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [fdre_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [fdre_pkg::CFG_BITS-1:0]       i_cfg_data
);
    import fdre_pkg::*;

    t_cfg                    r_cfg;
    logic                    cfg_hit;
    logic                    r_in_valid;
    t_in                     r_in;
    t_out [MAX_RES-1:0]      r_res;
    logic [RES_CNT_BITS-1:0] r_cnt;
    logic                    pop, advance;
    t_bundle                 bundle;

    always_comb begin
        case (i_cfg_idx)
            CFG_LEFT, CFG_TOP, CFG_WIDTH, CFG_HEIGHT, CFG_SCREEN: cfg_hit = i_cfg_we;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left   <= '0;
            r_cfg.top    <= '0;
            r_cfg.width  <= (CFG_BITS)'(1);
            r_cfg.height <= (CFG_BITS)'(1);
            r_cfg.screen <= (CFG_BITS)'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEFT:   r_cfg.left   <= i_cfg_data[COORD_BITS-1:0];
                CFG_TOP:    r_cfg.top    <= i_cfg_data[COORD_BITS-1:0];
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                CFG_SCREEN: r_cfg.screen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign pop         = o_out_valid && i_out_ready;
    assign advance     = r_in_valid && ((r_cnt == '0) || ((r_cnt == 1'b1) && pop));
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_cnt != '0;
    assign o_out_data  = r_res[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    fdre_core #(
        .COUNT_BITS (COUNT_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_hit),
        .i_step   (advance),
        .i_pix    (r_in),
        .i_cfg    (r_cfg),
        .o_bundle (bundle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (advance) begin
            r_cnt <= bundle.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // commands leave from slot 0; the rest shift down on each transaction
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= bundle.entry;
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
        end
    end

endmodule

FILE: src/fdre_checker.sv
module fdre_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input fdre_pkg::t_in                     i_in_data,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input fdre_pkg::t_out                    o_out_data,
    input logic                              i_cfg_we,
    input logic [fdre_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input logic [fdre_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import fdre_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output command dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("block not idle after reset");

    a_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != K_UPDATE |->
            o_out_data.box_w == '0 && o_out_data.box_h == '0)
        else $error("box size on a command other than partial update");

    a_box_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == K_UPDATE |->
            o_out_data.box_w != '0 && o_out_data.box_h != '0 && o_out_data.last)
        else $error("partial update with empty box or not last");

endmodule

bind frame_diff_run_encoder_unit fdre_checker u_fdre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data)
);

FILE: tb/fdre_command_checker.sv
module fdre_command_checker #(
    parameter int COUNT_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  fdre_pkg::t_in                     i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  fdre_pkg::t_out                    i_out_data,
    input  logic                              i_cfg_we,
    input  logic [fdre_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [fdre_pkg::CFG_BITS-1:0]     i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_cmd_count
);
    import fdre_pkg::*;

    localparam int                    SUM_W     = COUNT_BITS + CFG_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    t_cfg                  regs;
    logic [COORD_BITS-1:0] col, row;
    logic [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
    logic [PIX_W-1:0]      colour;
    logic [COUNT_BITS-1:0] skip_cnt, run_cnt;
    logic                  run_open, dirty;
    t_out                  pixel_cmds[$];
    t_out                  expected_cmds[$];
    int                    fails, checked;

    function automatic logic [CFG_BITS-1:0] usable_size(input logic [CFG_BITS-1:0] s);
        if (s == '0) begin
            return CFG_BITS'(1);
        end
        if (s > SIZE_LIMIT) begin
            return SIZE_LIMIT;
        end
        return s;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                     input logic [CFG_BITS-1:0] b);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(b);
        return (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_BITS-1:0];
    endfunction

    function automatic int field_bad(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic add_cmd(input t_kind k, input logic [VALUE_W-1:0] v,
                           input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                           input logic [CFG_BITS-1:0] bw, input logic [CFG_BITS-1:0] bh);
        t_out c;
        c.kind  = k;
        c.value = v;
        c.pos_x = px;
        c.pos_y = py;
        c.box_w = bw;
        c.box_h = bh;
        c.last  = 1'b0;
        pixel_cmds.push_back(c);
    endtask

    task automatic restart_region();
        col      = regs.left;
        row      = regs.top;
        skip_cnt = '0;
        run_open = 1'b0;
        run_cnt  = '0;
        dirty    = 1'b0;
        min_x    = '0;
        max_x    = '0;
        min_y    = '0;
        max_y    = '0;
    endtask

    task automatic close_run();
        if (run_open) begin
            add_cmd(K_REPEAT, VALUE_W'(run_cnt), '0, '0, '0, '0);
            run_open = 1'b0;
            run_cnt  = '0;
        end
    endtask

    task automatic predict_pixel(input t_in px);
        logic [CFG_BITS-1:0]   w, h;
        logic [COORD_BITS-1:0] col_off, row_off;
        t_out                  tail;
        w       = usable_size(regs.width);
        h       = usable_size(regs.height);
        col_off = col - regs.left;
        row_off = row - regs.top;
        pixel_cmds.delete();

        if (px.old_pixel != px.new_pixel) begin
            if (!dirty) begin
                add_cmd(K_RESET_POS, '0, regs.left, regs.top, '0, '0);
                dirty = 1'b1;
                min_x = col;
                max_x = col;
                min_y = row;
                max_y = row;
            end else begin
                if (col < min_x) min_x = col;
                if (col > max_x) max_x = col;
                if (row < min_y) min_y = row;
                if (row > max_y) max_y = row;
            end
            if (skip_cnt != '0) begin
                add_cmd(K_SKIP, VALUE_W'(skip_cnt), '0, '0, '0, '0);
                skip_cnt = '0;
            end
            if (px.new_pixel != colour) begin
                close_run();
                add_cmd(K_PUT, px.new_pixel, '0, '0, '0, '0);
                colour = px.new_pixel;
            end else if (run_open) begin
                run_cnt = sat_add(run_cnt, CFG_BITS'(1));
            end else begin
                run_open = 1'b1;
                run_cnt  = COUNT_BITS'(1);
            end
        end else begin
            close_run();
            skip_cnt = sat_add(skip_cnt, CFG_BITS'(1));
        end

        if ({1'b0, col_off} >= w - CFG_BITS'(1)) begin
            if ({1'b0, row_off} >= h - CFG_BITS'(1)) begin
                close_run();
                if (dirty) begin
                    add_cmd(K_UPDATE, '0, min_x, min_y,
                            CFG_BITS'(max_x) - CFG_BITS'(min_x) + CFG_BITS'(1),
                            CFG_BITS'(max_y) - CFG_BITS'(min_y) + CFG_BITS'(1));
                end
                restart_region();
            end else begin
                // row gap on the screen: skipped pixels, and it breaks a run
                if (regs.screen > w) begin
                    skip_cnt = sat_add(skip_cnt, regs.screen - w);
                    close_run();
                end
                col = regs.left;
                row = row + 1'b1;
            end
        end else begin
            col = col + 1'b1;
        end

        if (pixel_cmds.size() > 0) begin
            tail      = pixel_cmds[pixel_cmds.size()-1];
            tail.last = 1'b1;
            pixel_cmds[pixel_cmds.size()-1] = tail;
        end
        foreach (pixel_cmds[i]) expected_cmds.push_back(pixel_cmds[i]);
    endtask

    always @(posedge i_clk) begin : monitor
        t_out want;
        int   bad;
        if (!i_rst_n) begin
            regs.left   = '0;
            regs.top    = '0;
            regs.width  = CFG_BITS'(1);
            regs.height = CFG_BITS'(1);
            regs.screen = CFG_BITS'(1);
            colour      = '0;
            restart_region();
            expected_cmds.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEFT: begin
                        regs.left = i_cfg_data[COORD_BITS-1:0];
                        restart_region();
                    end
                    CFG_TOP: begin
                        regs.top = i_cfg_data[COORD_BITS-1:0];
                        restart_region();
                    end
                    CFG_WIDTH: begin
                        regs.width = i_cfg_data;
                        restart_region();
                    end
                    CFG_HEIGHT: begin
                        regs.height = i_cfg_data;
                        restart_region();
                    end
                    CFG_SCREEN: begin
                        regs.screen = i_cfg_data;
                        restart_region();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_pixel(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (expected_cmds.size() == 0) begin
                    $error("command with nothing expected: kind %0d value %0h",
                           i_out_data.kind, i_out_data.value);
                    fails++;
                end else begin
                    want = expected_cmds.pop_front();
                    bad  = field_bad("kind", 32'(want.kind), 32'(i_out_data.kind))
                         + field_bad("value", want.value, i_out_data.value)
                         + field_bad("pos_x", 32'(want.pos_x), 32'(i_out_data.pos_x))
                         + field_bad("pos_y", 32'(want.pos_y), 32'(i_out_data.pos_y))
                         + field_bad("box_w", 32'(want.box_w), 32'(i_out_data.box_w))
                         + field_bad("box_h", 32'(want.box_h), 32'(i_out_data.box_h))
                         + field_bad("last", 32'(want.last), 32'(i_out_data.last));
                    fails += bad;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_cmds.size();
        o_cmd_count  <= checked;
    end

endmodule

FILE: tb/tb_frame_diff_run_encoder_unit.sv
module tb_frame_diff_run_encoder_unit;
    import fdre_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_PIXELS = 320;
    localparam int HOLD_CYCLES   = 240;
    localparam int TALL_ROWS     = 64;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid, in_ready;
    logic                    out_valid, out_ready;
    t_in                     in_data;
    t_out                    out_data;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [CFG_BITS-1:0]     cfg_data;
    int                      fail_count, pending, cmd_count;
    int                      pixels_sent, regions_done;
    bit                      steady_flow, hold_req;
    logic [PIX_W-1:0]        palette[4];

    frame_diff_run_encoder_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fdre_command_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_cmd_count (cmd_count)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= steady_flow || ($urandom_range(99) >= 7);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_region(input int left, input int top, input int width,
                              input int height, input int screen);
        write_reg(CFG_LEFT, CFG_BITS'(left));
        write_reg(CFG_TOP, CFG_BITS'(top));
        write_reg(CFG_WIDTH, CFG_BITS'(width));
        write_reg(CFG_HEIGHT, CFG_BITS'(height));
        write_reg(CFG_SCREEN, CFG_BITS'(screen));
    endtask

    // returns right after the edge that took the transaction; valid stays high
    task automatic send_pixel(input logic [PIX_W-1:0] old_px, input logic [PIX_W-1:0] new_px);
        while (!steady_flow && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{old_pixel: old_px, new_pixel: new_px};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pixels_sent++;
    endtask

    // wait for every expected command, then the block's latency
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_colour();
        if ($urandom_range(99) < 80) begin
            return palette[$urandom_range(3)];
        end
        return $urandom();
    endfunction

    task automatic send_random_pixel(input int change_pct);
        logic [PIX_W-1:0] fresh, flip;
        fresh = pick_colour();
        flip  = $urandom() | (PIX_W'(1) << $urandom_range(PIX_W-1));
        if ($urandom_range(99) < change_pct) begin
            send_pixel(fresh ^ flip, fresh);
        end else begin
            send_pixel(fresh, fresh);
        end
    endtask

    initial begin : stimulus
        int target, w, h, n, pct, left, top, screen;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_we      <= 1'b0;
        cfg_idx     <= '0;
        cfg_data    <= '0;
        pixels_sent  = 0;
        regions_done = 0;
        steady_flow  = 1'b0;
        hold_req     = 1'b0;
        palette[0]   = '0;
        palette[1]   = '1;
        palette[2]   = $urandom();
        palette[3]   = $urandom();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: 1x1 region, colour zero
        send_pixel(32'h1234_5678, 32'h1234_5678);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        settle();

        // columns and rows wrap past 4095, with a row gap on the screen
        set_region(4094, 4095, 4, 2, 6);
        send_pixel(32'hA5A5_0F0F, 32'hA5A5_0F0F);
        send_pixel(32'h0000_0000, 32'hA5A5_0F0F);
        send_pixel(32'h0000_0000, 32'hA5A5_0F0F);
        send_pixel(32'h0000_0000, 32'hA5A5_0F0F);
        send_pixel(32'h5A5A_F0F0, 32'h5A5A_F0F0);
        send_pixel(32'h0000_0001, 32'h5A5A_F0F0);
        send_pixel(32'h0000_0002, 32'h5A5A_F0F0);
        send_pixel(32'h5A5A_F0F0, 32'h5A5A_F0F0);
        settle();

        // narrow screen: the run carries on into the next row
        set_region(8, 3, 3, 2, 2);
        repeat (6) send_pixel(32'h0000_0000, 32'h5A5A_F0F0);
        settle();

        // zero sizes act as one; left has bit 12 set
        set_region(8191, 0, 0, 0, 0);
        send_pixel(32'h0000_0005, 32'h0000_0006);
        settle();

        // unused register indexes must not disturb the region in progress
        set_region(10, 20, 2, 2, 4);
        send_pixel(32'h0000_0000, 32'h0000_0007);
        send_pixel(32'h0000_0009, 32'h0000_0009);
        settle();
        for (int i = int'(CFG_SCREEN) + 1; i < (1 << CFG_IDX_BITS); i++) begin
            write_reg(CFG_IDX_BITS'(i), '1);
        end
        send_pixel(32'h0000_0000, 32'h0000_0007);
        send_pixel(32'h0000_0003, 32'h0000_0008);
        settle();

        // oversized sizes, region abandoned by the next write
        set_region(100, 200, 4097, 8191, 8191);
        repeat (5) send_random_pixel(70);
        settle();

        // tall one-column region on a wide screen: long skips between rows
        set_region(0, 0, 1, TALL_ROWS, 8191);
        for (int i = 0; i < TALL_ROWS; i++) begin
            if (i == 40 || i == TALL_ROWS - 1) begin
                send_pixel(~palette[3], palette[3]);
            end else begin
                send_pixel(32'h0BAD_F00D, 32'h0BAD_F00D);
            end
        end
        settle();

        target = pixels_sent + RANDOM_PIXELS;
        w = 1;
        h = 1;
        while (pixels_sent < target) begin
            if (regions_done == 0 || (regions_done != 6 && $urandom_range(99) < 60)) begin
                settle();
                if ($urandom_range(99) < 10) begin
                    write_reg(CFG_IDX_BITS'($urandom_range(int'(CFG_SCREEN) + 1,
                                                           (1 << CFG_IDX_BITS) - 1)),
                              CFG_BITS'($urandom()));
                end
                w    = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 8);
                h    = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 6);
                left = ($urandom_range(99) < 25) ? $urandom_range(4088, 4095)
                                                 : $urandom_range(8191);
                top  = ($urandom_range(99) < 25) ? $urandom_range(4090, 4095)
                                                 : $urandom_range(8191);
                case ($urandom_range(3))
                    0:       screen = $urandom_range((w == 0) ? 1 : w);
                    1:       screen = ((w == 0) ? 1 : w) + $urandom_range(1, 4);
                    2:       screen = $urandom_range(8191);
                    default: screen = (w == 0) ? 1 : w;
                endcase
                set_region(left, top, w, h, screen);
            end
            steady_flow = (regions_done >= 12 && regions_done < 18);
            n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            if ($urandom_range(99) < 15 && n > 1) begin
                n = $urandom_range(1, n - 1);
            end
            case ($urandom_range(4))
                0:       pct = 0;
                1:       pct = 20;
                2:       pct = 50;
                3:       pct = 90;
                default: pct = 100;
            endcase
            // long receiver hold-off while the stream keeps coming
            if (regions_done == 6) begin
                hold_req = 1'b1;
                n        = 24;
                pct      = 100;
            end
            repeat (n) send_random_pixel(pct);
            regions_done++;
        end
        steady_flow = 1'b0;
        settle();

        $display("Encoder run: %0d pixel transactions, %0d commands checked",
                 pixels_sent, cmd_count);
        $display("Directed corners, long row skips and %0d random regions", regions_done);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/fdre_pkg.sv
src/fdre_core.sv
src/frame_diff_run_encoder_unit.sv
src/fdre_checker.sv
tb/fdre_command_checker.sv
tb/tb_frame_diff_run_encoder_unit.sv
